[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Sizes, request and status codes, and circular slot arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Store geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = 5;

  // Request codes
  localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [1:0] MODE_POP_BACK   = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [PTR_BITS-1:0] SLOT_LAST  = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(DEPTH);

  typedef logic [PTR_BITS-1:0]  slot_t;
  typedef logic [CNT_BITS-1:0]  count_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // Advance a slot, wrapping past the last one
  function automatic slot_t slot_next(input slot_t s);
    slot_t r;
    if (s == SLOT_LAST) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

  // Step a slot back, wrapping below zero
  function automatic slot_t slot_prev(input slot_t s);
    slot_t r;
    if (s == '0) begin
      r = SLOT_LAST;
    end else begin
      r = s - slot_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed words in a circular store
//
// One request per input transaction: in_tuser selects push front, push back,
// pop front or pop back; in_tdata carries the word to push. Each request
// yields exactly one output transaction with the popped word (zero for pushes
// and failed pops), a status code and the occupancy after the request.
// A push into a full store is dropped with the full status; a pop from an
// empty store returns zero with the empty status.
// A push or a failed pop shows its result in the cycle after the
// transaction; a successful pop passes through the registered read of the
// word store and then the output register. One request is in flight at a time,
// so no new request is taken while a pop read is pending.
// A new request is taken in the cycle the pending result is being taken.
// When the receiver stalls, the result holds in the output register and no
// new request is taken. Reset empties the queue (pointers and count to zero);
// store contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
  input  wire         clk,
  input  wire         rst_n,
  // Request channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] push_word
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  // Result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] pop_word, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import dq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Word store
  word_t mem [DEPTH];

  logic   state_r, state_nxt;
  slot_t  front_r, front_nxt;
  slot_t  back_r, back_nxt;
  count_t count_r, count_nxt;

  logic   out_valid_r, out_valid_nxt;
  word_t  pop_word_r, pop_word_nxt;
  logic [1:0] status_r, status_nxt;
  count_t occ_r, occ_nxt;

  word_t  rd_data_r;
  logic   rd_en;
  slot_t  rd_addr;
  logic   wr_en;
  slot_t  wr_addr;
  logic   in_fire;
  logic   store_empty;
  logic   is_full;

  assign in_tready   = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire     = in_tvalid && in_tready;
  assign store_empty = (count_r == '0);
  assign is_full     = (count_r == COUNT_FULL);

  // Decode the request, update pointers and steer store accesses
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    pop_word_nxt  = pop_word_r;
    status_nxt    = status_r;
    occ_nxt       = occ_r;
    rd_en         = 1'b0;
    rd_addr       = front_r;
    wr_en         = 1'b0;
    wr_addr       = back_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pop_word_nxt  = '0;
          status_nxt    = STATUS_OK;
          out_valid_nxt = 1'b1;
          unique case (in_tuser)
            MODE_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = STATUS_FULL;
              end else begin
                front_nxt = slot_prev(front_r);
                wr_en     = 1'b1;
                wr_addr   = slot_prev(front_r);
                count_nxt = count_r + count_t'(1);
              end
            end
            MODE_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = STATUS_FULL;
              end else begin
                back_nxt  = slot_next(back_r);
                wr_en     = 1'b1;
                wr_addr   = back_r;
                count_nxt = count_r + count_t'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (store_empty) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                front_nxt     = slot_next(front_r);
                rd_en         = 1'b1;
                rd_addr       = front_r;
                count_nxt     = count_r - count_t'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = ST_READ;
              end
            end
            MODE_POP_BACK: begin
              if (store_empty) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                back_nxt      = slot_prev(back_r);
                rd_en         = 1'b1;
                rd_addr       = slot_prev(back_r);
                count_nxt     = count_r - count_t'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = ST_READ;
              end
            end
            default: begin
              status_nxt = STATUS_OK;
            end
          endcase
          occ_nxt = count_nxt;
        end
      end
      ST_READ: begin
        // Present the word read from the store
        pop_word_nxt  = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_tdata[WORD_BITS-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pop_word_r <= pop_word_nxt;
    status_r   <= status_nxt;
    occ_r      <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, occ_r, pop_word_r};
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

[verif/deque_checker.sv]
// ----------------------------------------------------------------------------
// deque_checker: result predictor and scoreboard for double_ended_queue
// Watches the request and result channels. Each request transaction is run
// through a private deque model to predict its result. Each result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_checker
  import dq_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] push_word
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [39:0] out_tdata,  // [31:0] pop_word, [36:32] occupancy, [39:37] zero
  input  wire  [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          empty_hits,
  output int          full_hits
);

  typedef struct packed {
    word_t      pop_word;
    logic [1:0] status;
    count_t     occupancy;
  } deque_result_t;

  deque_result_t expected_results[$];

  // Private copy of the deque
  word_t slot_words [DEPTH];
  int    head_slot;
  int    tail_slot;
  int    held_words;

  int    fails;
  int    checked;
  int    empties;
  int    fulls;

  // Apply one request to the private deque and return its result
  function automatic deque_result_t apply_deque_request(input logic [1:0] mode,
                                                        input word_t word);
    deque_result_t r;
    r = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (held_words >= DEPTH) begin
          r.status = STATUS_FULL;
        end else if (mode == MODE_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slot_words[head_slot] = word;
          held_words++;
        end else begin
          slot_words[tail_slot] = word;
          tail_slot = (tail_slot + 1) % DEPTH;
          held_words++;
        end
      end
      default: begin
        if (held_words == 0) begin
          r.status = STATUS_EMPTY;
        end else if (mode == MODE_POP_FRONT) begin
          r.pop_word = slot_words[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          held_words--;
        end else begin
          tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
          r.pop_word = slot_words[tail_slot];
          held_words--;
        end
      end
    endcase
    r.occupancy = count_t'(held_words);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      head_slot  = 0;
      tail_slot  = 0;
      held_words = 0;
      expected_results.delete();
    end else begin
      // Compare the result transaction with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: pop_word %0d status %0d occupancy %0d",
                 $signed(out_tdata[31:0]), out_tuser, out_tdata[36:32]);
          fails++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.status == STATUS_EMPTY) empties++;
          if (want.status == STATUS_FULL) fulls++;
          if (out_tdata[31:0] !== want.pop_word) begin
            $error("pop_word mismatch: expected %0d, actual %0d",
                   $signed(want.pop_word), $signed(out_tdata[31:0]));
            fails++;
          end
          if (out_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser);
            fails++;
          end
          if (out_tdata[36:32] !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d",
                   want.occupancy, out_tdata[36:32]);
            fails++;
          end
          if (out_tdata[39:37] !== 3'b000) begin
            $error("pad mismatch: expected %0d, actual %0d", 3'b000, out_tdata[39:37]);
            fails++;
          end
        end
      end
      // Predict the result of an accepted request transaction
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(),
                                apply_deque_request(in_tuser, word_t'(in_tdata)));
      end
    end
    fail_count    <= fails;
    pending       <= expected_results.size();
    checked_count <= checked;
    empty_hits    <= empties;
    full_hits     <= fulls;
  end

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for double_ended_queue
// Drives a directed opening (empty pops, extreme words, filling to full and
// rejected pushes), then random phases biased toward filling, draining or
// balanced use, with random idling on both channels, a long receiver
// hold-off and a drain pause. The checker module does all prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import dq_pkg::*;

  localparam int REQUEST_TOTAL   = 1450;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int CALM_TAIL       = 150;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] push_word
  logic [1:0]  in_tuser   = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] pop_word, [36:32] occupancy, [39:37] zero
  logic [1:0]  out_tuser;         // [1:0] status

  logic        idle_on    = 1'b1;
  int          hold_off_asked = 0;
  int          hold_off_served;
  int          requests_sent;

  int          fail_count;
  int          pending;
  int          checked_count;
  int          empty_hits;
  int          full_hits;

  double_ended_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  deque_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .empty_hits    (empty_hits),
    .full_hits     (full_hits)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bound the run
  initial begin
    #400000;
    $display("double_ended_queue test failed");
    $finish;
  end

  // Result side: random short stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    hold_off_served = 0;
    forever begin
      @(posedge clk);
      if (hold_off_asked != hold_off_served) begin
        hold_off_served++;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Mostly random words, sometimes an extreme one
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 11))
      0:       w = 32'h7FFF_FFFF;
      1:       w = 32'h8000_0000;
      2:       w = 32'h0000_0000;
      3:       w = 32'hFFFF_FFFF;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // Offer one request and hold it until the transaction completes
  task automatic issue_request(input logic [1:0] mode, input logic [31:0] word);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          phase_left;
    int          push_pct;
    logic [1:0]  mode;
    logic [31:0] w;
    requests_sent = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, extreme words, fill with wrap, rejected pushes
    issue_request(MODE_POP_FRONT, 32'hDEAD_BEEF);
    issue_request(MODE_POP_BACK, 32'h1234_5678);
    issue_request(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
    issue_request(MODE_PUSH_BACK, 32'h8000_0000);
    issue_request(MODE_POP_BACK, 32'h0);
    issue_request(MODE_POP_FRONT, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) w = 32'h0;
      else if (i == 1) w = 32'hFFFF_FFFF;
      else if (i[0]) w = ~(32'h1 << i);
      else w = 32'h1 << i;
      issue_request(i[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, w);
    end
    issue_request(MODE_PUSH_FRONT, 32'h5555_5555);
    issue_request(MODE_PUSH_BACK, 32'hAAAA_AAAA);
    wait_for_drain();

    // Random phases biased toward filling, draining or balanced traffic
    phase_left = 0;
    push_pct = 50;
    while (requests_sent < REQUEST_TOTAL) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      if (requests_sent == 400) hold_off_asked <= hold_off_asked + 1;
      if (requests_sent == 800) wait_for_drain();
      if (requests_sent == REQUEST_TOTAL - CALM_TAIL) idle_on <= 1'b0;
      if ($urandom_range(0, 99) < push_pct) begin
        mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      end else begin
        mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
      end
      issue_request(mode, pick_word());
    end

    wait_for_drain();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests, checked %0d results across fill, drain and wrap phases.",
             requests_sent, checked_count);
    $display("Saw %0d pops on an empty queue and %0d pushes rejected as full.",
             empty_hits, full_hits);
    if (fail_count == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/dq_pkg.sv
rtl/double_ended_queue.sv
verif/deque_checker.sv
verif/tb.sv
